// ===== design/cgtq_pkg.sv =====
// ----------------------------------------------------------------------------
// Credit-gated transmit queue package
// Shared constants, command codes, transaction structs and a slot-index helper.
// ----------------------------------------------------------------------------
package cgtq_pkg;

	localparam int QUEUE_DEPTH     = 64;
	localparam int INITIAL_CREDITS = 10;
	localparam int CREDIT_MAX      = 255;

	localparam int HANDLE_W = 32;
	localparam int DUR_W    = 16;
	localparam int ENTRY_W  = HANDLE_W + DUR_W;
	localparam int LIMIT_W  = 7;
	localparam int QLEN_W   = 7;
	localparam int CLEFT_W  = 8;

	localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CTOP   = (CREDIT_MAX > INITIAL_CREDITS) ? CREDIT_MAX : INITIAL_CREDITS;
	localparam int CRED_W = (CTOP > 1) ? $clog2(CTOP + 1) : 1;
	localparam int CMP_W  = (LIMIT_W > OCC_W) ? LIMIT_W : OCC_W;

	localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = LIMIT_W'(64);

	typedef enum logic [1:0] {
		CMD_ARRIVE = 2'd0,
		CMD_CREDIT = 2'd1,
		CMD_DONE   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic                valid;
		cmd_t                cmd;
		logic [HANDLE_W-1:0] handle;
		logic [DUR_W-1:0]    duration;
	} event_t;

	typedef struct packed {
		logic                valid;
		logic                sent;
		logic [HANDLE_W-1:0] sent_handle;
		logic [DUR_W-1:0]    sent_duration;
		logic                dropped;
		logic [QLEN_W-1:0]   queue_length;
		logic [CLEFT_W-1:0]  credits_left;
		logic                busy_res;
	} result_t;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + IDX_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== design/cgtq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cgtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/cgtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Credit-gated transmit queue control
// Queue pointers, occupancy, credits, server state, head register and the
// packet store. Computes the result of one registered event per cycle.
// ----------------------------------------------------------------------------
module cgtq_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cgtq_pkg::event_t               evt,
	input  logic [cgtq_pkg::LIMIT_W-1:0]   queue_limit,
	output cgtq_pkg::result_t              res
);
	import cgtq_pkg::*;

	logic [OCC_W-1:0]   occ_q, occ_a, occ_d;
	logic [IDX_W-1:0]   head_idx_q, head_idx_d, tail_idx_q, tail_idx_d, rd_addr;
	logic [CRED_W-1:0]  cred_q, cred_a, cred_d;
	logic               srv_busy_q, busy_a, busy_d;
	logic [ENTRY_W-1:0] head_data_q, head_data_d;
	logic               byp_flag_q, byp_flag_d;
	logic [ENTRY_W-1:0] byp_data_q;
	logic [ENTRY_W-1:0] rd_data, second, in_entry, sent_entry;
	logic [CMP_W-1:0]   limit_ext, depth_c, eff_limit;
	logic               is_arrive, full, enq, drop, snd;

	assign in_entry  = {evt.handle, evt.duration};
	assign second    = byp_flag_q ? byp_data_q : rd_data;
	assign limit_ext = CMP_W'(queue_limit);
	assign depth_c   = CMP_W'(QUEUE_DEPTH);
	assign eff_limit = (limit_ext > depth_c) ? depth_c : limit_ext;

	always_comb begin
		is_arrive = evt.valid && (evt.cmd == CMD_ARRIVE);
		full      = CMP_W'(occ_q) >= eff_limit;
		enq       = is_arrive && !full;
		drop      = is_arrive && full;

		cred_a = cred_q;
		if (evt.valid && (evt.cmd == CMD_CREDIT) && (cred_q < CRED_W'(CREDIT_MAX))) begin
			cred_a = cred_q + CRED_W'(1);
		end
		busy_a = srv_busy_q;
		if (evt.valid && (evt.cmd == CMD_DONE)) begin
			busy_a = 1'b0;
		end
		occ_a = occ_q + OCC_W'(enq);

		snd = evt.valid && (evt.cmd != CMD_NONE) && !busy_a &&
			(occ_a != '0) && (cred_a != '0);

		sent_entry = (occ_q == '0) ? in_entry : head_data_q;

		occ_d      = occ_a - OCC_W'(snd);
		cred_d     = cred_a - CRED_W'(snd);
		busy_d     = busy_a | snd;
		tail_idx_d = enq ? next_slot(tail_idx_q) : tail_idx_q;
		head_idx_d = snd ? next_slot(head_idx_q) : head_idx_q;

		if (snd) begin
			head_data_d = (occ_q >= OCC_W'(2)) ? second : in_entry;
		end else if ((occ_q == '0) && enq) begin
			head_data_d = in_entry;
		end else begin
			head_data_d = head_data_q;
		end

		rd_addr    = next_slot(head_idx_d);
		byp_flag_d = enq && (tail_idx_q == rd_addr);

		res.valid         = evt.valid;
		res.sent          = snd;
		res.sent_handle   = snd ? sent_entry[ENTRY_W-1:DUR_W] : '0;
		res.sent_duration = snd ? sent_entry[DUR_W-1:0] : '0;
		res.dropped       = drop;
		res.queue_length  = QLEN_W'(occ_d);
		res.credits_left  = CLEFT_W'(cred_d);
		res.busy_res      = busy_d;
	end

	cgtq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (enq),
		.waddr (tail_idx_q),
		.wdata (in_entry),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q      <= '0;
			head_idx_q <= '0;
			tail_idx_q <= '0;
			cred_q     <= CRED_W'(INITIAL_CREDITS);
			srv_busy_q <= 1'b0;
			byp_flag_q <= 1'b0;
		end else begin
			occ_q      <= occ_d;
			head_idx_q <= head_idx_d;
			tail_idx_q <= tail_idx_d;
			cred_q     <= cred_d;
			srv_busy_q <= busy_d;
			byp_flag_q <= byp_flag_d;
		end
	end

	always_ff @(posedge clk) begin
		head_data_q <= head_data_d;
		byp_data_q  <= in_entry;
	end

endmodule

// ===== design/credit_gated_tx_queue.sv =====
// ----------------------------------------------------------------------------
// Credit-gated transmit queue
// Transmit queue with tail drop and credit-based flow control.
// ----------------------------------------------------------------------------
// One command is accepted in every cycle: busy stays low. Each accepted
// transaction produces exactly one result. Done goes high at the clock edge
// after the one that accepted the command and stays high for one cycle. Results
// come out in order and the receiver cannot stall them. The rate rests on the
// update of the queue pointers, credit count and head register for each command,
// with the head's successor fetched ahead from the packet store.
module credit_gated_tx_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      command,
	input  logic [cgtq_pkg::HANDLE_W-1:0]   packet_handle,
	input  logic [cgtq_pkg::DUR_W-1:0]      packet_duration,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cgtq_pkg::LIMIT_W-1:0]    cfg_data,
	output logic                            done,
	output logic                            sent,
	output logic [cgtq_pkg::HANDLE_W-1:0]   sent_handle,
	output logic [cgtq_pkg::DUR_W-1:0]      sent_duration,
	output logic                            dropped,
	output logic [cgtq_pkg::QLEN_W-1:0]     queue_length,
	output logic [cgtq_pkg::CLEFT_W-1:0]    credits_left,
	output logic                            busy_res
);
	import cgtq_pkg::*;

	event_t              evt_s1;
	result_t             res_c, res_s2;
	logic [LIMIT_W-1:0]  limit_q;
	logic                accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_s1  <= '0;
			res_s2  <= '0;
			limit_q <= QUEUE_LIMIT_RESET;
		end else begin
			evt_s1.valid    <= accept;
			evt_s1.cmd      <= cmd_t'(command);
			evt_s1.handle   <= packet_handle;
			evt_s1.duration <= packet_duration;
			res_s2          <= res_c;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
		end
	end

	cgtq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt_s1),
		.queue_limit (limit_q),
		.res         (res_c)
	);

	assign done          = res_s2.valid;
	assign sent          = res_s2.sent;
	assign sent_handle   = res_s2.sent_handle;
	assign sent_duration = res_s2.sent_duration;
	assign dropped       = res_s2.dropped;
	assign queue_length  = res_s2.queue_length;
	assign credits_left  = res_s2.credits_left;
	assign busy_res      = res_s2.busy_res;

endmodule
